/* rtl/mat3_pkg.sv */
// Shared definitions for the 3x3 matrix add/subtract/multiply unit:
// opcodes, the sequencer's control word and its microprogram ROM.
// No dependencies.
package mat3_pkg;

    localparam int DIM_DEFAULT = 3;
    localparam int DATA_W      = 32;

    localparam logic [2:0] OP_LOAD_A = 3'd0;
    localparam logic [2:0] OP_LOAD_B = 3'd1;
    localparam logic [2:0] OP_ADD    = 3'd2;
    localparam logic [2:0] OP_SUB    = 3'd3;
    localparam logic [2:0] OP_MUL    = 3'd4;

    typedef logic [2:0] step_t;

    localparam step_t STEP_IDLE = 3'd0;
    localparam step_t STEP_READ = 3'd1;
    localparam step_t STEP_EXEC = 3'd2;
    localparam step_t STEP_ACC  = 3'd3;
    localparam step_t STEP_EMIT = 3'd4;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_DISPATCH,
        JMP_KLOOP,
        JMP_ELEM
    } jmp_t;

    typedef struct packed {
        logic  rd_en;
        logic  alu_en;
        logic  acc_en;
        logic  emit;
        jmp_t  jmp;
        step_t target;
    } uctl_t;

    // Microprogram: one control word per step.
    function automatic uctl_t urom(input step_t step);
        uctl_t w;
        w = '{rd_en: 1'b0, alu_en: 1'b0, acc_en: 1'b0, emit: 1'b0,
              jmp: JMP_DISPATCH, target: STEP_READ};
        case (step)
            STEP_IDLE:
            begin
                w.jmp    = JMP_DISPATCH;
                w.target = STEP_READ;
            end
            STEP_READ:
            begin
                w.rd_en  = 1'b1;
                w.jmp    = JMP_NEXT;
            end
            STEP_EXEC:
            begin
                w.alu_en = 1'b1;
                w.jmp    = JMP_NEXT;
            end
            STEP_ACC:
            begin
                w.acc_en = 1'b1;
                w.jmp    = JMP_KLOOP;
                w.target = STEP_READ;
            end
            STEP_EMIT:
            begin
                w.emit   = 1'b1;
                w.jmp    = JMP_ELEM;
                w.target = STEP_READ;
            end
            default:
            begin
                w.jmp    = JMP_DISPATCH;
                w.target = STEP_READ;
            end
        endcase
        return w;
    endfunction

endpackage

/* rtl/matrix3x3_add_sub_multiply.sv */
// Holds two DIMxDIM matrices, A and B, in small memories and sweeps out A+B, A-B or A*B
// one element per beat, in row-major order; the last beat of a sweep carries last.
// A microcoded sequencer (step counter plus control ROM) steps one read port per matrix,
// one 32x32 multiplier/adder and an accumulator. Results show for exactly one cycle on
// result_valid and the receiver cannot hold them off.
// A load is written at its accept beat, and busy stays low, so loads may follow each
// other every cycle. An add or subtract keeps busy high while it steps read, execute,
// accumulate and emit for each element; a multiply keeps it high while it runs the
// dot-product loop: read, multiply, accumulate for each of the DIM terms, then emit.
// Uses mat3_pkg.
module matrix3x3_add_sub_multiply #(
    parameter int DIM = mat3_pkg::DIM_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  opcode,
    input  logic [1:0]                  row,
    input  logic [1:0]                  col,
    input  logic signed [mat3_pkg::DATA_W-1:0] element,
    output logic                        result_valid,
    output logic [1:0]                  out_row,
    output logic [1:0]                  out_col,
    output logic signed [mat3_pkg::DATA_W-1:0] out_value,
    output logic                        last
);

    localparam int DEPTH  = DIM * DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = $clog2(DIM);
    localparam int DW     = mat3_pkg::DATA_W;
    localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(DIM - 1);
    localparam logic [ADDR_W-1:0] DIM_A    = ADDR_W'(DIM);
    localparam logic [7:0]        DIM_8    = 8'(DIM);

    // Storage
    logic [DW-1:0] mem_a [DEPTH];
    logic [DW-1:0] mem_b [DEPTH];

    // Sequencer
    mat3_pkg::step_t step_reg, step_next;
    mat3_pkg::uctl_t ctl;

    logic [2:0]       op_reg;
    logic [IDX_W-1:0] r_reg, c_reg, k_reg;
    logic [DW-1:0]    a_rd_reg, b_rd_reg, alu_reg, acc_reg;
    logic             valid_reg, last_reg;
    logic [1:0]       out_row_reg, out_col_reg;
    logic [DW-1:0]    out_value_reg;

    logic accept, is_compute, in_range, op_is_mul;
    logic r_last, c_last, k_last, k_loop;
    logic [7:0]        waddr_full;
    logic [ADDR_W-1:0] waddr, a_addr, b_addr;
    logic [3:0]        r_ext, c_ext;

    assign ctl        = mat3_pkg::urom(step_reg);
    assign busy       = (step_reg != mat3_pkg::STEP_IDLE);
    assign accept     = start && !busy;
    assign is_compute = (opcode == mat3_pkg::OP_ADD) || (opcode == mat3_pkg::OP_SUB)
                        || (opcode == mat3_pkg::OP_MUL);
    assign in_range   = ({6'b0, row} < DIM_8) && ({6'b0, col} < DIM_8);
    assign waddr_full = {6'b0, row} * DIM_8 + {6'b0, col};
    assign waddr      = waddr_full[ADDR_W-1:0];

    assign op_is_mul = (op_reg == mat3_pkg::OP_MUL);
    assign r_last    = (r_reg == IDX_LAST);
    assign c_last    = (c_reg == IDX_LAST);
    assign k_last    = (k_reg == IDX_LAST);
    assign k_loop    = op_is_mul && !k_last;

    // A walks its row by k for a product, B its column; add/sub read the same element
    assign a_addr = ADDR_W'(r_reg) * DIM_A + (op_is_mul ? ADDR_W'(k_reg) : ADDR_W'(c_reg));
    assign b_addr = op_is_mul ? ADDR_W'(k_reg) * DIM_A + ADDR_W'(c_reg)
                              : ADDR_W'(r_reg) * DIM_A + ADDR_W'(c_reg);

    assign r_ext = 4'(r_reg);
    assign c_ext = 4'(c_reg);

    always_comb
    begin
        case (ctl.jmp)
            mat3_pkg::JMP_NEXT:
                step_next = step_reg + 3'd1;
            mat3_pkg::JMP_DISPATCH:
                step_next = (accept && is_compute) ? ctl.target : mat3_pkg::STEP_IDLE;
            mat3_pkg::JMP_KLOOP:
                step_next = k_loop ? ctl.target : step_reg + 3'd1;
            mat3_pkg::JMP_ELEM:
                step_next = (r_last && c_last) ? mat3_pkg::STEP_IDLE : ctl.target;
            default:
                step_next = mat3_pkg::STEP_IDLE;
        endcase
    end

    // Memory write on a load beat, registered read on a read step
    always_ff @(posedge clk)
    begin
        if (accept && in_range && (opcode == mat3_pkg::OP_LOAD_A))
        begin
            mem_a[waddr] <= element;
        end
        if (accept && in_range && (opcode == mat3_pkg::OP_LOAD_B))
        begin
            mem_b[waddr] <= element;
        end
        if (ctl.rd_en)
        begin
            a_rd_reg <= mem_a[a_addr];
            b_rd_reg <= mem_b[b_addr];
        end
    end

    // Datapath payload
    always_ff @(posedge clk)
    begin
        if (accept && is_compute)
        begin
            op_reg <= opcode;
        end
        if (ctl.alu_en)
        begin
            case (op_reg)
                mat3_pkg::OP_ADD: alu_reg <= a_rd_reg + b_rd_reg;
                mat3_pkg::OP_SUB: alu_reg <= a_rd_reg - b_rd_reg;
                default:          alu_reg <= a_rd_reg * b_rd_reg;
            endcase
        end
        if (ctl.acc_en)
        begin
            acc_reg <= (op_is_mul && (k_reg != '0)) ? acc_reg + alu_reg : alu_reg;
        end
        if (ctl.emit)
        begin
            out_row_reg   <= r_ext[1:0];
            out_col_reg   <= c_ext[1:0];
            out_value_reg <= acc_reg;
            last_reg      <= r_last && c_last;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= mat3_pkg::STEP_IDLE;
            r_reg     <= '0;
            c_reg     <= '0;
            k_reg     <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= ctl.emit;
            if (accept && is_compute)
            begin
                r_reg <= '0;
                c_reg <= '0;
                k_reg <= '0;
            end
            else
            begin
                if (ctl.acc_en)
                begin
                    k_reg <= k_loop ? k_reg + 1'b1 : '0;
                end
                // advance row-major on each emitted beat
                if (ctl.emit)
                begin
                    if (c_last)
                    begin
                        c_reg <= '0;
                        r_reg <= r_last ? '0 : r_reg + 1'b1;
                    end
                    else
                    begin
                        c_reg <= c_reg + 1'b1;
                    end
                end
            end
        end
    end

    assign result_valid = valid_reg;
    assign out_row      = out_row_reg;
    assign out_col      = out_col_reg;
    assign out_value    = out_value_reg;
    assign last         = last_reg;

    // Checks
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |-> !busy)
        else $error("last beat shown while sequencer still busy");

    a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_compute) |=> !busy)
        else $error("load or unused opcode made the unit busy");

    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_compute) |=> busy)
        else $error("compute beat accepted but sequencer stayed idle");

    a_k_addsub: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && !op_is_mul) |-> (k_reg == '0))
        else $error("term counter moved during add or subtract");

    a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result beats on consecutive cycles");

endmodule
